// File: design/kvi_pkg.sv
// shared constants and types for the keyframe vector interpolator
package kvi_pkg;
    localparam int MaxKeys  = 64;
    localparam int SlotW    = $clog2(MaxKeys);
    localparam int CountW   = 7;
    localparam int FracBits = 16;
    localparam int TimeW    = 32;
    localparam int ValW     = 32;
    localparam int VecW     = 3 * ValW;
    localparam int KeyW     = TimeW + VecW;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_START  = 4'd1;
    localparam logic [3:0] OP_RDLAST = 4'd2;
    localparam logic [3:0] OP_CHKLST = 4'd3;
    localparam logic [3:0] OP_RDMID  = 4'd4;
    localparam logic [3:0] OP_CMPMID = 4'd5;
    localparam logic [3:0] OP_RDLO   = 4'd6;
    localparam logic [3:0] OP_GETLO  = 4'd7;
    localparam logic [3:0] OP_GETHI  = 4'd8;
    localparam logic [3:0] OP_DIVSTP = 4'd9;
    localparam logic [3:0] OP_FACTOR = 4'd10;
    localparam logic [3:0] OP_MUL    = 4'd11;
    localparam logic [3:0] OP_ADD    = 4'd12;
    localparam logic [3:0] OP_LOAD   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] lane;
    } t_cmd;

    typedef struct packed {
        logic past;      // query at or after the last key
        logic single;    // only one key
        logic search_done;
        logic flat;      // t1 <= t0
        logic div_done;
    } t_status;
endpackage

// File: design/kvi_if.sv
// valid/ready channel carrying one payload beat
interface kvi_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/keyframe_vector_interpolator.sv
// top level of the keyframe vector interpolator
// A load beat writes one keyframe and gives no result; the next beat is accepted after
// a wait state. A query beat reads the last key first; at or after it (or with one key)
// the result is made valid with no search. Otherwise a binary search over the single-port
// key table runs a read state and a compare state per probe (up to six probes), and the
// pair is fetched in the read, low and high states; a flat or falling pair stops there.
// Else a 48-step restoring divider and a factor state form the blend factor, and the
// three components are blended one multiplier at a time, each in a multiply state and
// an add state.
// One beat is in flight at a time; a result is held until taken before the next beat
// is accepted.
module keyframe_vector_interpolator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [kvi_pkg::CountW-1:0]   i_cfg_data,
    kvi_if.sink                          i_in,
    kvi_if.source                        o_out
);
    logic [kvi_pkg::CountW-1:0] r_key_count;
    kvi_pkg::t_cmd    cmd;
    kvi_pkg::t_status st;
    logic [kvi_pkg::VecW-1:0] vec;
    logic past, sat;

    // key count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_key_count <= kvi_pkg::CountW'(1);
        else if (i_cfg_we) r_key_count <= i_cfg_data;
    end

    kvi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.data[0]),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .i_status   (st),
        .o_cmd      (cmd)
    );

    kvi_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (st),
        .i_key_count(r_key_count),
        .i_slot     (i_in.data[6:1]),
        .i_instant  (i_in.data[38:7]),
        .i_vec      ({i_in.data[134:103], i_in.data[102:71], i_in.data[70:39]}),
        .o_vec      (vec),
        .o_past     (past),
        .o_sat      (sat)
    );

    assign o_out.data = {sat, past, vec};
endmodule

// File: design/kvi_ram.sv
// generic single-port ram with registered read
module kvi_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: design/kvi_ctrl.sv
// query sequencer for the interpolator
module kvi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_mode,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  kvi_pkg::t_status i_status,
    output kvi_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RDLAST = 4'd1, S_CHKLST = 4'd2,
        S_RDMID = 4'd3, S_CMPMID = 4'd4, S_RDLO = 4'd5, S_GETLO = 4'd6,
        S_GETHI = 4'd7, S_DIV = 4'd8, S_FACT = 4'd9, S_MUL = 4'd10,
        S_ADD = 4'd11, S_DONE = 4'd12, S_LOADW = 4'd13;

    logic [3:0] r_state, n_state;
    logic [1:0] r_lane, n_lane;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_lane  = r_lane;
        o_cmd.op   = kvi_pkg::OP_NONE;
        o_cmd.lane = r_lane;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode == kvi_pkg::MODE_QUERY) begin
                        o_cmd.op = kvi_pkg::OP_START;
                        n_state  = S_RDLAST;
                    end else begin
                        o_cmd.op = kvi_pkg::OP_LOAD;
                        n_state  = S_LOADW;
                    end
                end
            end
            S_LOADW: n_state = S_IDLE;
            S_RDLAST: begin
                o_cmd.op = kvi_pkg::OP_RDLAST;
                n_state  = S_CHKLST;
            end
            S_CHKLST: begin
                o_cmd.op = kvi_pkg::OP_CHKLST;
                if (i_status.past || i_status.single) n_state = S_DONE;
                else n_state = S_RDMID;
            end
            S_RDMID: begin
                if (i_status.search_done) begin
                    n_state = S_RDLO;
                end else begin
                    o_cmd.op = kvi_pkg::OP_RDMID;
                    n_state  = S_CMPMID;
                end
            end
            S_CMPMID: begin
                o_cmd.op = kvi_pkg::OP_CMPMID;
                n_state  = S_RDMID;
            end
            S_RDLO: begin
                o_cmd.op = kvi_pkg::OP_RDLO;
                n_state  = S_GETLO;
            end
            S_GETLO: begin
                o_cmd.op = kvi_pkg::OP_GETLO;
                n_state  = S_GETHI;
            end
            S_GETHI: begin
                o_cmd.op = kvi_pkg::OP_GETHI;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_status.flat) begin
                    n_state = S_DONE;
                end else if (i_status.div_done) begin
                    n_state = S_FACT;
                end else begin
                    o_cmd.op = kvi_pkg::OP_DIVSTP;
                end
            end
            S_FACT: begin
                o_cmd.op = kvi_pkg::OP_FACTOR;
                n_lane   = 2'd0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = kvi_pkg::OP_MUL;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = kvi_pkg::OP_ADD;
                if (r_lane == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_DONE: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lane  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
        end
    end

    // input and output never both open
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid overlap");
    // a result beat held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    // a taken result returns to idle
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> o_in_ready) else $error("no return to idle");
endmodule

// File: design/kvi_dp.sv
// key table, search registers, serial divider and blend datapath
module kvi_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kvi_pkg::t_cmd                 i_cmd,
    output kvi_pkg::t_status              o_status,
    input  logic [kvi_pkg::CountW-1:0]    i_key_count,
    input  logic [kvi_pkg::SlotW-1:0]     i_slot,
    input  logic [kvi_pkg::TimeW-1:0]     i_instant,
    input  logic [kvi_pkg::VecW-1:0]      i_vec,
    output logic [kvi_pkg::VecW-1:0]      o_vec,
    output logic                          o_past,
    output logic                          o_sat
);
    localparam int SW = kvi_pkg::SlotW;
    localparam int TW = kvi_pkg::TimeW;
    localparam int VW = kvi_pkg::ValW;
    localparam int FB = kvi_pkg::FracBits;
    localparam int NW = TW + FB;           // dividend width
    localparam int CW = $clog2(NW + 1);

    logic [SW:0]        r_lo, r_hi, r_last;
    logic [TW-1:0]      r_t, r_t0;
    logic [kvi_pkg::VecW-1:0] r_v0, r_v1;
    logic               r_neg;
    logic [NW-1:0]      r_quo;
    logic [TW:0]        r_rem;
    logic [TW-1:0]      r_den;
    logic [CW-1:0]      r_cnt;
    logic               r_flat;
    logic [VW:0]        r_fm;
    logic [2*VW+1:0]    r_prod;
    logic               r_pneg;
    logic [VW-1:0]      r_x [3];
    logic               r_past, r_sat, r_sing;

    // table read/write
    logic              we;
    logic [SW-1:0]     addr;
    logic [SW:0]       mid;
    logic [kvi_pkg::KeyW-1:0] rdata;
    logic [TW-1:0]     rt;
    logic [kvi_pkg::VecW-1:0] rv;
    logic [SW:0]       n_eff;

    assign n_eff = (i_key_count == '0) ? (SW+1)'(1) :
        (i_key_count > kvi_pkg::CountW'(kvi_pkg::MaxKeys)) ?
        (SW+1)'(kvi_pkg::MaxKeys) : i_key_count[SW:0];
    assign mid = (r_lo + r_hi) >> 1;
    assign we  = (i_cmd.op == kvi_pkg::OP_LOAD);
    assign rt  = rdata[kvi_pkg::KeyW-1 -: TW];
    assign rv  = rdata[kvi_pkg::VecW-1:0];

    always_comb begin
        case (i_cmd.op)
            kvi_pkg::OP_LOAD:   addr = i_slot;
            kvi_pkg::OP_RDLAST: addr = r_last[SW-1:0];
            kvi_pkg::OP_RDMID:  addr = mid[SW-1:0];
            kvi_pkg::OP_RDLO:   addr = r_lo[SW-1:0];
            kvi_pkg::OP_GETLO:  addr = SW'(r_lo + 1'b1);
            default:            addr = r_lo[SW-1:0];
        endcase
    end

    kvi_ram #(.W(kvi_pkg::KeyW), .D(kvi_pkg::MaxKeys)) u_tab (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata({i_instant, i_vec}),
        .o_rdata(rdata)
    );

    // divider step and blend helpers
    logic [TW:0]   rem_sh, rem_sub;
    logic [TW:0]   diff_m;
    logic signed [VW:0] bd, dd;
    logic [VW:0]   dm;
    logic [2*VW+1:0] q;
    logic signed [2*VW+1:0] sum;
    logic [NW:0]   qcl;

    assign rem_sh  = {r_rem[TW-1:0], r_quo[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    always_comb begin
        bd = $signed({r_v1[VW*i_cmd.lane + VW - 1], r_v1[VW*i_cmd.lane +: VW]});
        dd = $signed({r_v0[VW*i_cmd.lane + VW - 1], r_v0[VW*i_cmd.lane +: VW]});
        diff_m = bd - dd >= 0 ? (TW+1)'(bd - dd) : (TW+1)'(dd - bd);
        dm = diff_m;
        q = r_prod >> FB;
        sum = r_pneg ? (2*VW+2)'(dd) - $signed(q) : (2*VW+2)'(dd) + $signed(q);
        qcl = {1'b0, r_quo};
    end

    logic signed [VW:0] diff_s;
    assign diff_s = bd - dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_past <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            case (i_cmd.op)
                kvi_pkg::OP_START: begin
                    r_t    <= i_instant;
                    r_last <= n_eff - 1'b1;
                    r_sing <= (n_eff == (SW+1)'(1));
                    r_lo   <= '0;
                    r_hi   <= n_eff;
                    r_past <= 1'b0;
                    r_sat  <= 1'b0;
                    r_flat <= 1'b0;
                end
                kvi_pkg::OP_CHKLST: begin
                    r_past <= (r_t >= rt);
                    r_v0   <= rv;
                    r_x[0] <= rv[VW-1:0];
                    r_x[1] <= rv[2*VW-1:VW];
                    r_x[2] <= rv[3*VW-1:2*VW];
                end
                kvi_pkg::OP_CMPMID: begin
                    if (rt < r_t) r_lo <= mid;
                    else r_hi <= mid;
                end
                kvi_pkg::OP_RDLO: begin
                    if (r_lo > r_last - 2'd1) r_lo <= r_last - 2'd1;
                end
                kvi_pkg::OP_GETLO: begin
                    r_t0 <= rt;
                    r_v0 <= rv;
                    r_x[0] <= rv[VW-1:0];
                    r_x[1] <= rv[2*VW-1:VW];
                    r_x[2] <= rv[3*VW-1:2*VW];
                    r_neg <= (r_t < rt);
                    r_quo <= {((r_t < rt) ? rt - r_t : r_t - rt), FB'(0)};
                end
                kvi_pkg::OP_GETHI: begin
                    r_v1   <= rv;
                    r_flat <= (rt <= r_t0);
                    r_den  <= rt - r_t0;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end
                kvi_pkg::OP_DIVSTP: begin
                    if (!rem_sub[TW]) begin
                        r_rem <= rem_sub;
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                kvi_pkg::OP_FACTOR: begin
                    if (r_neg) begin
                        if (qcl > (NW+1)'(33'h80000000)) begin
                            r_fm <= (VW+1)'(33'h80000000);
                            r_sat <= 1'b1;
                        end else r_fm <= r_quo[VW:0];
                    end else begin
                        if (qcl > (NW+1)'(33'h7FFFFFFF)) begin
                            r_fm <= (VW+1)'(33'h7FFFFFFF);
                            r_sat <= 1'b1;
                        end else r_fm <= r_quo[VW:0];
                    end
                end
                kvi_pkg::OP_MUL: begin
                    r_prod <= (2*VW+2)'(dm) * (2*VW+2)'(r_fm);
                    r_pneg <= (diff_s < 0) != (r_neg && r_fm != '0);
                end
                kvi_pkg::OP_ADD: begin
                    if (sum > (2*VW+2)'(32'sh7FFFFFFF)) begin
                        r_x[i_cmd.lane] <= 32'h7FFFFFFF;
                        r_sat <= 1'b1;
                    end else if (sum < -(2*VW+2)'(33'sh80000000)) begin
                        r_x[i_cmd.lane] <= 32'h80000000;
                        r_sat <= 1'b1;
                    end else r_x[i_cmd.lane] <= sum[VW-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_status.past        = (i_cmd.op == kvi_pkg::OP_CHKLST) && (r_t >= rt);
    assign o_status.single      = r_sing;
    assign o_status.search_done = (r_hi - r_lo == (SW+1)'(1));
    assign o_status.flat        = r_flat;
    assign o_status.div_done    = (r_cnt == CW'(NW));
    assign o_vec  = {r_x[2], r_x[1], r_x[0]};
    assign o_past = r_past;
    assign o_sat  = r_sat;
endmodule

// File: tb/keyframe_vector_interpolator_tb.sv
// testbench for keyframe_vector_interpolator: key loads, blended queries, scoreboard checks
module keyframe_vector_interpolator_tb;
    localparam int ClkHalf     = 10;
    localparam int CycleLimit  = 2000000;
    localparam int DrainCycles = 120;
    localparam longint ValMax  = 64'sd2147483647;
    localparam longint ValMin  = -64'sd2147483648;

    // mode sits in the low bit of the beat
    typedef struct packed {
        logic [kvi_pkg::ValW-1:0]   value_z;
        logic [kvi_pkg::ValW-1:0]   value_y;
        logic [kvi_pkg::ValW-1:0]   value_x;
        logic [kvi_pkg::TimeW-1:0]  instant;
        logic [kvi_pkg::SlotW-1:0]  key_slot;
        logic                       mode;
    } t_key_beat;

    // out_x sits in the low bits of the beat
    typedef struct packed {
        logic                     saturated;
        logic                     past_end;
        logic [kvi_pkg::ValW-1:0] out_z;
        logic [kvi_pkg::ValW-1:0] out_y;
        logic [kvi_pkg::ValW-1:0] out_x;
    } t_blend_beat;

    // scoreboard: mirror of the key table plus queue of expected blends
    class blend_scoreboard;
        logic [kvi_pkg::TimeW-1:0] key_times [kvi_pkg::MaxKeys];
        longint           key_vecs  [kvi_pkg::MaxKeys][3];
        int               key_count;
        t_blend_beat      pending [$];
        int               errors;

        function new();
            key_count = 1;
            errors    = 0;
            foreach (key_times[i]) begin
                key_times[i] = '0;
                for (int k = 0; k < 3; k++) key_vecs[i][k] = 0;
            end
        endfunction

        function automatic longint clip(longint v, ref bit sat);
            if (v > ValMax) begin
                sat = 1;
                return ValMax;
            end
            if (v < ValMin) begin
                sat = 1;
                return ValMin;
            end
            return v;
        endfunction

        function automatic longint mix(longint a, longint b, longint f, ref bit sat);
            longint diff;
            longint unsigned dm, fm, q;
            bit neg;
            diff = b - a;
            dm   = (diff < 0) ? longint'(-diff) : diff;
            fm   = (f < 0) ? longint'(-f) : f;
            q    = (dm * fm) >> kvi_pkg::FracBits;
            neg  = (diff < 0) != (f < 0);
            return clip(neg ? a - longint'(q) : a + longint'(q), sat);
        endfunction

        function automatic t_blend_beat pack_vec(longint v[3], bit past, bit sat);
            t_blend_beat r;
            r.out_x     = v[0][31:0];
            r.out_y     = v[1][31:0];
            r.out_z     = v[2][31:0];
            r.past_end  = past;
            r.saturated = sat;
            return r;
        endfunction

        function automatic t_blend_beat interpolate(logic [kvi_pkg::TimeW-1:0] t);
            int n, lo, hi, mid;
            logic [kvi_pkg::TimeW-1:0] t0, t1;
            longint num, f;
            longint unsigned mag, qu;
            longint res[3];
            bit sat;
            sat = 0;
            n = key_count;
            if (n == 0) n = 1;
            if (n > kvi_pkg::MaxKeys) n = kvi_pkg::MaxKeys;
            if (t >= key_times[n-1]) return pack_vec(key_vecs[n-1], 1, 0);
            if (n == 1) return pack_vec(key_vecs[0], 0, 0);
            lo = 0;
            hi = n;
            while (hi - lo != 1) begin
                mid = (lo + hi) / 2;
                if (key_times[mid] < t) lo = mid;
                else hi = mid;
            end
            if (lo > n - 2) lo = n - 2;
            hi = lo + 1;
            t0 = key_times[lo];
            t1 = key_times[hi];
            // flat or falling pair returns the lower key
            if (t1 <= t0) return pack_vec(key_vecs[lo], 0, 0);
            num = longint'({32'b0, t}) - longint'({32'b0, t0});
            mag = ((num < 0) ? longint'(-num) : num) << kvi_pkg::FracBits;
            qu  = mag / longint'({32'b0, t1 - t0});
            if (num < 0) begin
                if (qu > 64'h80000000) begin
                    qu  = 64'h80000000;
                    sat = 1;
                end
                f = -longint'(qu);
            end else begin
                if (qu > 64'h7FFFFFFF) begin
                    qu  = 64'h7FFFFFFF;
                    sat = 1;
                end
                f = qu;
            end
            for (int k = 0; k < 3; k++) res[k] = mix(key_vecs[lo][k], key_vecs[hi][k], f, sat);
            return pack_vec(res, 0, sat);
        endfunction

        // accepted input beat: loads update the mirror, queries queue a blend
        function void note_input(t_key_beat b);
            if (b.mode == kvi_pkg::MODE_LOAD) begin
                key_times[b.key_slot]   = b.instant;
                key_vecs[b.key_slot][0] = longint'(signed'(b.value_x));
                key_vecs[b.key_slot][1] = longint'(signed'(b.value_y));
                key_vecs[b.key_slot][2] = longint'(signed'(b.value_z));
            end else begin
                pending.push_back(interpolate(b.instant));
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h, want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_blend_beat got);
            t_blend_beat want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.out_x, 32'h0);
                return;
            end
            want = pending.pop_front();
            if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
            if (got.past_end !== want.past_end)
                report_mismatch("past_end", 32'(got.past_end), 32'(want.past_end));
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        endtask
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [kvi_pkg::CountW-1:0] i_cfg_data = '0;

    kvi_if #(.W($bits(t_key_beat)))   key_ch ();
    kvi_if #(.W($bits(t_blend_beat))) blend_ch ();

    keyframe_vector_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (key_ch.sink),
        .o_out      (blend_ch.source)
    );

    blend_scoreboard sb = new();
    int  idle_pct  = 0;
    int  stall_pct = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  cycles    = 0;

    always #(ClkHalf) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 400;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        blend_ch.ready <= i_rst_n && hold_left == 0 && $urandom_range(0, 99) >= stall_pct;
    end

    // input and result monitors
    always @(posedge i_clk) begin
        if (i_rst_n && key_ch.valid && key_ch.ready) sb.note_input(t_key_beat'(key_ch.data));
        if (i_rst_n && blend_ch.valid && blend_ch.ready)
            sb.check_result(t_blend_beat'(blend_ch.data));
    end

    task send_beat(t_key_beat b);
        if ($urandom_range(0, 99) < idle_pct) begin
            key_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        key_ch.valid <= 1;
        key_ch.data  <= b;
        do @(posedge i_clk); while (!key_ch.ready);
    endtask

    task stop_sending();
        key_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    task wait_drained();
        stop_sending();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task set_key_count(int n);
        wait_drained();
        i_cfg_we   <= 1;
        i_cfg_data <= n[kvi_pkg::CountW-1:0];
        @(posedge i_clk);
        sb.key_count = n;
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_key_beat load_beat(int slot, logic [31:0] t);
        t_key_beat b;
        b.mode     = kvi_pkg::MODE_LOAD;
        b.key_slot = slot[kvi_pkg::SlotW-1:0];
        b.instant  = t;
        b.value_x  = rand_val();
        b.value_y  = rand_val();
        b.value_z  = rand_val();
        return b;
    endfunction

    function automatic t_key_beat query_beat(logic [31:0] t);
        t_key_beat b;
        b          = '0;
        b.mode     = kvi_pkg::MODE_QUERY;
        b.key_slot = kvi_pkg::SlotW'($urandom);
        b.instant  = t;
        b.value_x  = $urandom;
        b.value_y  = $urandom;
        b.value_z  = $urandom;
        return b;
    endfunction

    // reload all slots with rising times, some flat steps and falls
    task load_table();
        logic [31:0] t;
        t = $urandom_range(0, 32'h7FFF_FFFF);
        for (int s = 0; s < kvi_pkg::MaxKeys; s++) begin
            send_beat(load_beat(s, t));
            case ($urandom_range(0, 19))
                0: t = t;
                1: t = t - $urandom_range(1, 1000);
                2: t = t + $urandom_range(32'h0100_0000, 32'h0200_0000);
                default: t = t + $urandom_range(1, 32'h0010_0000);
            endcase
        end
    endtask

    function automatic logic [31:0] pick_instant();
        int n, k;
        logic [31:0] a, b;
        n = sb.key_count;
        if (n == 0) n = 1;
        if (n > kvi_pkg::MaxKeys) n = kvi_pkg::MaxKeys;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 11))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return sb.key_times[k];
            3: return sb.key_times[n-1];
            4: return sb.key_times[n-1] - 1;
            5: return $urandom_range(0, sb.key_times[0]);
            6: return $urandom;
            default: begin
                a = sb.key_times[k];
                b = (k + 1 < n) ? sb.key_times[k+1] : a;
                return (b > a) ? $urandom_range(a, b) : a;
            end
        endcase
    endfunction

    task random_phase(int items);
        for (int i = 0; i < items; i++) begin
            if (i == items / 3) begin
                // block fills up while the receiver holds off
                hold_reqs++;
            end
            if (i == (2 * items) / 3) begin
                stop_sending();
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) == 0) begin
                send_beat(load_beat($urandom_range(0, kvi_pkg::MaxKeys - 1), $urandom));
            end else begin
                send_beat(query_beat(pick_instant()));
            end
        end
        stop_sending();
    endtask

    initial begin
        int counts[8];
        t_key_beat b;
        counts = '{64, 1, 0, 127, 2, 37, 5, 64};
        key_ch.valid <= 0;
        key_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extreme keys at the start, equal times toward the end
        b = load_beat(0, 32'h0001_0000);
        b.value_x = 32'h80000000;
        b.value_y = 32'h80000000;
        b.value_z = 32'h7FFFFFFF;
        send_beat(b);
        b = load_beat(1, 32'h0001_0001);
        b.value_x = 32'h7FFFFFFF;
        b.value_y = 32'h00000000;
        b.value_z = 32'h80000000;
        send_beat(b);
        for (int s = 2; s < kvi_pkg::MaxKeys; s++)
            send_beat(load_beat(s, 32'h0002_0000 + ((s < 40 ? s : 40) << 12)));
        send_beat(query_beat(32'h0000_0000));
        set_key_count(64);
        send_beat(query_beat(32'h0000_0000));
        send_beat(query_beat(32'hFFFF_FFFF));
        send_beat(query_beat(32'h0001_0000));
        send_beat(query_beat(32'h0001_0001));
        send_beat(query_beat(32'h0002_8800));
        send_beat(query_beat(32'h0002_8000 + 32'h0800));
        send_beat(query_beat(32'h0002_A800));
        send_beat(query_beat(32'h0002_1800));
        stop_sending();

        // random phases across key counts, idle patterns and stall patterns
        for (int p = 0; p < 8; p++) begin
            idle_pct  = (p % 4 == 1) ? 78 : (p % 4 == 3) ? 37 : 0;
            stall_pct = (p % 4 == 2) ? 78 : (p % 4 == 3) ? 37 : 0;
            set_key_count(counts[p]);
            if (p % 2 == 1) load_table();
            random_phase(48);
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
